// ===== hdl/pscc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor Chebyshev correction package
// Shared widths, codes and arithmetic helpers for the correction table block.
// ----------------------------------------------------------------------------
package pscc_pkg;

   // Default geometry and series length.
   localparam int MAX_DEGREE_DEF = 12;
   localparam int LAYERS_DEF     = 6;
   localparam int LADDERS_DEF    = 16;
   localparam int WAFERS_DEF     = 7;
   localparam int HYBRIDS_DEF    = 2;

   // Field widths fixed by the item format.
   localparam int COEF_W  = 32;
   localparam int COORD_W = 20;
   localparam int DEG_W   = 5;
   localparam int IDX_W   = 4;
   localparam int SUM_W   = 38;

   // Multiplier widths: signed A times signed B, B split into two partial products.
   localparam int MUL_A_W  = 32;
   localparam int MUL_B_W  = 33;
   localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
   localparam int MUL_LO_W = 17;

   // Division by three: floor(n/3) = (n * DIV3_MUL) >> DIV3_SHIFT for n < 2^20.
   localparam logic [21:0] DIV3_MUL   = 22'd699051;
   localparam int          DIV3_SHIFT = 21;

   // Chebyshev terms are Q.30 and clipped to a magnitude of 2^32-1.
   localparam logic signed [MUL_B_W-1:0] T_ONE   = 33'sd1073741824;
   localparam logic signed [MUL_P_W-1:0] T_LIMIT = 65'sd4294967295;

   typedef enum logic [1:0] {
      CMD_WR_DEGREE = 2'd0,
      CMD_WR_COEF   = 2'd1,
      CMD_EVALUATE  = 2'd2,
      CMD_RESERVED  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_EVALUATED = 2'd0,
      ST_NO_CORR   = 2'd1,
      ST_RANGE_ERR = 2'd2,
      ST_WRITE_OK  = 2'd3
   } status_type;

   // Round v / 2^s to nearest, halves away from zero.
   function automatic logic signed [MUL_P_W-1:0] rnd_shift(
      input logic signed [MUL_P_W-1:0] v,
      input int                        s
   );
      logic signed [MUL_P_W-1:0] half;
      logic signed [MUL_P_W-1:0] neg;
      half = MUL_P_W'(65'sd1 <<< (s - 1));
      neg  = {{(MUL_P_W-1){1'b0}}, v[MUL_P_W-1]};
      return (v + half - neg) >>> s;
   endfunction

endpackage

// ===== hdl/pscc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module pscc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/pscc_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor Chebyshev correction multiplier
// Signed 32 x 33 bit product built from a low and a high partial product, registered in turn and then summed.
// ----------------------------------------------------------------------------
module pscc_mul (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [pscc_pkg::MUL_A_W-1:0]    op_a,
   input  logic signed [pscc_pkg::MUL_B_W-1:0]    op_b,
   output logic                                   done,
   output logic signed [pscc_pkg::MUL_P_W-1:0]    product
);

   localparam int LO_P_W = pscc_pkg::MUL_A_W + pscc_pkg::MUL_LO_W + 1;
   localparam int HI_W   = pscc_pkg::MUL_B_W - pscc_pkg::MUL_LO_W;
   localparam int HI_P_W = pscc_pkg::MUL_A_W + HI_W;

   logic signed [pscc_pkg::MUL_A_W-1:0] a_ff;
   logic signed [pscc_pkg::MUL_B_W-1:0] b_ff;
   logic signed [LO_P_W-1:0]            p_lo_ff, p_lo_in;
   logic signed [HI_P_W-1:0]            p_hi_ff, p_hi_in;
   logic signed [pscc_pkg::MUL_P_W-1:0] prod_ff, prod_in;
   logic [2:0]                          step_ff;
   logic                                done_ff;

   // Low part uses the unsigned low bits of B, high part the signed upper bits.
   always_comb begin
      p_lo_in = LO_P_W'(a_ff) *
                LO_P_W'($signed({1'b0, b_ff[pscc_pkg::MUL_LO_W-1:0]}));
      p_hi_in = HI_P_W'(a_ff) *
                HI_P_W'($signed(b_ff[pscc_pkg::MUL_B_W-1:pscc_pkg::MUL_LO_W]));
      prod_in = (pscc_pkg::MUL_P_W'(p_hi_ff) <<< pscc_pkg::MUL_LO_W) +
                pscc_pkg::MUL_P_W'(p_lo_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= {step_ff[1:0], start};
         done_ff <= step_ff[2];
      end
      if (start) begin
         a_ff <= op_a;
         b_ff <= op_b;
      end
      if (step_ff[0]) begin
         p_lo_ff <= p_lo_in;
      end
      if (step_ff[1]) begin
         p_hi_ff <= p_hi_in;
      end
      if (step_ff[2]) begin
         prod_ff <= prod_in;
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

// ===== hdl/per_sensor_chebyshev_correction_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-sensor shifted Chebyshev correction
// Correction table per sensor half with write and evaluate commands.
// ----------------------------------------------------------------------------
// The block stores, for each sensor half (layer, ladder, wafer, hybrid, all
// one-based), a degree and up to MAX_DEGREE+1 signed Q15.16 coefficients, and
// evaluates the shifted Chebyshev series at t = 2|u|/3 - 1 for a Q3.16
// coordinate u. The degree table lives in one RAM and the coefficients in a
// second RAM; one item is handled at a time. After reset the block first
// clears the degree table, one entry per cycle, over all of its
// LAYERS*LADDERS*WAFERS*HYBRIDS entries (1344 with the default geometry);
// no item is accepted during that pass. A write item passes the decode,
// base, execute and done states before the next item can be accepted,
// and its result enters the output register as it leaves the done state.
// An evaluate item also runs a term loop over degree+1 terms: each term
// runs one coefficient multiply and one recurrence multiply side by side on
// two partial-product multipliers started together, and every term depends
// on the previous one, so the term loop sets the evaluate time.
// Index errors and entries without a correction pass the same states as a write.
// The result sits in an output register, so the next item is taken while a
// finished result still waits; a result that is ready while the output
// register is still full holds the block until that register is taken.
// Coefficients that were never written must not be evaluated.
// ----------------------------------------------------------------------------
module per_sensor_chebyshev_correction_top #(
   parameter int MAX_DEGREE = pscc_pkg::MAX_DEGREE_DEF,
   parameter int LAYERS     = pscc_pkg::LAYERS_DEF,
   parameter int LADDERS    = pscc_pkg::LADDERS_DEF,
   parameter int WAFERS     = pscc_pkg::WAFERS_DEF,
   parameter int HYBRIDS    = pscc_pkg::HYBRIDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Command items.
   input  logic        req_tvalid,
   output logic        req_tready,
   // layer[2:0], ladder[7:3], wafer[10:8], hybrid[12:11], degree[17:13],
   // coef_index[21:18], coefficient[53:22], coordinate[73:54], zero[79:74]
   input  logic [79:0] req_tdata,
   // command[1:0]
   input  logic [1:0]  req_tuser,
   // Result items.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // value[31:0]
   output logic [31:0] rsp_tdata,
   // status[1:0], saturated[2]
   output logic [2:0]  rsp_tuser
);

   localparam int ENTRIES = LAYERS * LADDERS * WAFERS * HYBRIDS;
   localparam int COEFS   = MAX_DEGREE + 1;
   localparam int CDEPTH  = ENTRIES * COEFS;
   localparam int EW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW      = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
   localparam int PW      = pscc_pkg::MUL_P_W;
   localparam int TW      = pscc_pkg::MUL_B_W;

   typedef enum logic [8:0] {
      S_CLEAR  = 9'b000000001,
      S_IDLE   = 9'b000000010,
      S_DECODE = 9'b000000100,
      S_BASE   = 9'b000001000,
      S_EXEC   = 9'b000010000,
      S_LSTART = 9'b000100000,
      S_LWAIT  = 9'b001000000,
      S_FIN    = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Captured item fields.
   logic [1:0]                                 cmd_ff, cmd_in;
   logic [2:0]                                 layer_ff, layer_in;
   logic [4:0]                                 ladder_ff, ladder_in;
   logic [2:0]                                 wafer_ff, wafer_in;
   logic [1:0]                                 hybrid_ff, hybrid_in;
   logic [pscc_pkg::DEG_W-1:0]                 degree_ff, degree_in;
   logic [pscc_pkg::IDX_W-1:0]                 cidx_ff, cidx_in;
   logic [pscc_pkg::COEF_W-1:0]                coef_ff, coef_in;
   logic [pscc_pkg::COORD_W-1:0]               coord_ff, coord_in;

   // Address and evaluation datapath.
   logic [EW-1:0]                              clr_ff, clr_in;
   logic [EW-1:0]                              entry_ff, entry_in;
   logic                                       ok_ff, ok_in;
   logic [CW-1:0]                              cbase_ff, cbase_in;
   logic [17:0]                                x_ff, x_in;
   logic signed [pscc_pkg::COORD_W-1:0]        t_ff, t_in;
   logic signed [TW-1:0]                       t1_ff, t1_in;
   logic                                       t1_sat_ff, t1_sat_in;
   logic signed [TW-1:0]                       tc_ff, tc_in;
   logic signed [TW-1:0]                       tp_ff, tp_in;
   logic [pscc_pkg::IDX_W-1:0]                 n_ff, n_in;
   logic [pscc_pkg::IDX_W-1:0]                 d_ff, d_in;
   logic signed [pscc_pkg::SUM_W-1:0]          sum_ff, sum_in;
   logic                                       sat_ff, sat_in;

   // Result waiting for the output register.
   logic [31:0]                                res_value_ff, res_value_in;
   pscc_pkg::status_type                       res_status_ff, res_status_in;
   logic                                       res_sat_ff, res_sat_in;

   // Output register.
   logic                                       rsp_tvalid_ff, rsp_tvalid_in;
   logic [31:0]                                rsp_value_ff, rsp_value_in;
   logic [2:0]                                 rsp_user_ff, rsp_user_in;

   // Memory ports.
   logic                                       deg_we;
   logic [EW-1:0]                              deg_waddr;
   logic [pscc_pkg::DEG_W-1:0]                 deg_wdata;
   logic                                       deg_re;
   logic [pscc_pkg::DEG_W-1:0]                 deg_rdata;
   logic                                       coef_we;
   logic [CW-1:0]                              coef_waddr;
   logic                                       coef_re;
   logic [CW-1:0]                              coef_raddr;
   logic [pscc_pkg::COEF_W-1:0]                coef_rdata;

   // Multipliers.
   logic                                       mul_start;
   logic                                       term_done, rec_done;
   logic signed [PW-1:0]                       term_prod, rec_prod;

   // Combinational helpers.
   logic                                       accept;
   logic                                       in_range;
   logic [pscc_pkg::COORD_W-1:0]               abs_u;
   logic [20:0]                                abs_u1;
   logic [42:0]                                div3_prod;
   logic signed [33:0]                         t_sh;
   logic signed [PW-1:0]                       term_rnd;
   logic signed [PW-1:0]                       rec_next;
   logic signed [TW-1:0]                       t_next;
   logic                                       t_next_sat;
   logic                                       deg_ok;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   pscc_ram #(
      .WIDTH (pscc_pkg::DEG_W),
      .DEPTH (ENTRIES)
   ) u_deg_ram (
      .clock   (clock),
      .wr_en   (deg_we),
      .wr_addr (deg_waddr),
      .wr_data (deg_wdata),
      .rd_en   (deg_re),
      .rd_addr (entry_ff),
      .rd_data (deg_rdata)
   );

   pscc_ram #(
      .WIDTH (pscc_pkg::COEF_W),
      .DEPTH (CDEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_waddr),
      .wr_data (coef_ff),
      .rd_en   (coef_re),
      .rd_addr (coef_raddr),
      .rd_data (coef_rdata)
   );

   // Coefficient times Chebyshev term.
   pscc_mul u_term_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    ($signed(coef_rdata)),
      .op_b    (tc_ff),
      .done    (term_done),
      .product (term_prod)
   );

   // t times the current term, for the next step of the recurrence.
   pscc_mul u_rec_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (pscc_pkg::MUL_A_W'(t_ff)),
      .op_b    (tc_ff),
      .done    (rec_done),
      .product (rec_prod)
   );

   // Range check, |u|/3 rounded, first-order term and the next recurrence term.
   always_comb begin
      in_range = (layer_ff  != 3'd0) && (int'(layer_ff)  <= LAYERS)  &&
                 (ladder_ff != 5'd0) && (int'(ladder_ff) <= LADDERS) &&
                 (wafer_ff  != 3'd0) && (int'(wafer_ff)  <= WAFERS)  &&
                 (hybrid_ff != 2'd0) && (int'(hybrid_ff) <= HYBRIDS);
      abs_u     = coord_ff[pscc_pkg::COORD_W-1] ? (~coord_ff + 1'b1) : coord_ff;
      abs_u1    = 21'(abs_u) + 21'd1;
      div3_prod = 43'(abs_u1) * 43'(pscc_pkg::DIV3_MUL);
      t_sh      = 34'(t_ff) <<< 14;
      deg_ok    = !deg_rdata[pscc_pkg::DEG_W-1] &&
                  (int'(deg_rdata[pscc_pkg::DEG_W-2:0]) <= MAX_DEGREE);
      term_rnd  = pscc_pkg::rnd_shift(term_prod, 30);
      rec_next  = pscc_pkg::rnd_shift(rec_prod, 15) - PW'(tp_ff);
      if (n_ff == '0) begin
         t_next     = t1_ff;
         t_next_sat = t1_sat_ff;
      end else if (rec_next > pscc_pkg::T_LIMIT) begin
         t_next     = TW'(pscc_pkg::T_LIMIT);
         t_next_sat = 1'b1;
      end else if (rec_next < -pscc_pkg::T_LIMIT) begin
         t_next     = TW'(-pscc_pkg::T_LIMIT);
         t_next_sat = 1'b1;
      end else begin
         t_next     = TW'(rec_next);
         t_next_sat = 1'b0;
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      layer_in      = layer_ff;
      ladder_in     = ladder_ff;
      wafer_in      = wafer_ff;
      hybrid_in     = hybrid_ff;
      degree_in     = degree_ff;
      cidx_in       = cidx_ff;
      coef_in       = coef_ff;
      coord_in      = coord_ff;
      clr_in        = clr_ff;
      entry_in      = entry_ff;
      ok_in         = ok_ff;
      cbase_in      = cbase_ff;
      x_in          = x_ff;
      t_in          = t_ff;
      t1_in         = t1_ff;
      t1_sat_in     = t1_sat_ff;
      tc_in         = tc_ff;
      tp_in         = tp_ff;
      n_in          = n_ff;
      d_in          = d_ff;
      sum_in        = sum_ff;
      sat_in        = sat_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      res_sat_in    = res_sat_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      deg_we        = 1'b0;
      deg_waddr     = entry_ff;
      deg_wdata     = degree_ff;
      deg_re        = 1'b0;
      coef_we       = 1'b0;
      coef_waddr    = cbase_ff + CW'(cidx_ff);
      coef_re       = 1'b0;
      coef_raddr    = cbase_ff;
      mul_start     = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            deg_we    = 1'b1;
            deg_waddr = clr_ff;
            deg_wdata = '1;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == EW'(ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in    = req_tuser;
               layer_in  = req_tdata[2:0];
               ladder_in = req_tdata[7:3];
               wafer_in  = req_tdata[10:8];
               hybrid_in = req_tdata[12:11];
               degree_in = req_tdata[17:13];
               cidx_in   = req_tdata[21:18];
               coef_in   = req_tdata[53:22];
               coord_in  = req_tdata[73:54];
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            ok_in    = in_range && (pscc_pkg::cmd_type'(cmd_ff) != pscc_pkg::CMD_RESERVED);
            entry_in = EW'((((int'(layer_ff) - 1) * LADDERS + (int'(ladder_ff) - 1))
                            * WAFERS + (int'(wafer_ff) - 1)) * HYBRIDS
                           + (int'(hybrid_ff) - 1));
            x_in     = 18'(div3_prod >> pscc_pkg::DIV3_SHIFT);
            state_in = S_BASE;
         end
         S_BASE: begin
            deg_re   = 1'b1;
            cbase_in = CW'(entry_ff * COEFS);
            t_in     = $signed(20'({x_ff, 1'b0}) - 20'd65536);
            state_in = S_EXEC;
         end
         S_EXEC: begin
            res_value_in  = '0;
            res_sat_in    = 1'b0;
            res_status_in = pscc_pkg::ST_RANGE_ERR;
            state_in      = S_DONE;
            if (t_sh > 34'sd4294967295) begin
               t1_in     = 33'sd4294967295;
               t1_sat_in = 1'b1;
            end else if (t_sh < -34'sd4294967295) begin
               t1_in     = -33'sd4294967295;
               t1_sat_in = 1'b1;
            end else begin
               t1_in     = TW'(t_sh);
               t1_sat_in = 1'b0;
            end
            if (ok_ff) begin
               case (pscc_pkg::cmd_type'(cmd_ff))
                  pscc_pkg::CMD_WR_DEGREE: begin
                     deg_we        = 1'b1;
                     res_status_in = pscc_pkg::ST_WRITE_OK;
                  end
                  pscc_pkg::CMD_WR_COEF: begin
                     if (int'(cidx_ff) <= MAX_DEGREE) begin
                        coef_we       = 1'b1;
                        res_status_in = pscc_pkg::ST_WRITE_OK;
                     end
                  end
                  default: begin
                     if (!deg_ok) begin
                        res_status_in = pscc_pkg::ST_NO_CORR;
                     end else begin
                        coef_re  = 1'b1;
                        d_in     = deg_rdata[pscc_pkg::DEG_W-2:0];
                        n_in     = '0;
                        tc_in    = pscc_pkg::T_ONE;
                        tp_in    = '0;
                        sum_in   = '0;
                        sat_in   = 1'b0;
                        state_in = S_LSTART;
                     end
                  end
               endcase
            end
         end
         S_LSTART: begin
            mul_start = 1'b1;
            if (n_ff < d_ff) begin
               coef_re    = 1'b1;
               coef_raddr = cbase_ff + CW'(n_ff) + 1'b1;
            end
            state_in = S_LWAIT;
         end
         S_LWAIT: begin
            if (term_done) begin
               sum_in = sum_ff + pscc_pkg::SUM_W'(term_rnd);
               tp_in  = tc_ff;
               tc_in  = t_next;
               if (t_next_sat && (n_ff < d_ff)) begin
                  sat_in = 1'b1;
               end
               if (n_ff == d_ff) begin
                  state_in = S_FIN;
               end else begin
                  n_in     = n_ff + 1'b1;
                  state_in = S_LSTART;
               end
            end
         end
         S_FIN: begin
            res_status_in = pscc_pkg::ST_EVALUATED;
            if (sum_ff > 38'sd2147483647) begin
               res_value_in = 32'h7FFF_FFFF;
               res_sat_in   = 1'b1;
            end else if (sum_ff < -38'sd2147483648) begin
               res_value_in = 32'h8000_0000;
               res_sat_in   = 1'b1;
            end else begin
               res_value_in = 32'(sum_ff);
               res_sat_in   = sat_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_user_in   = {res_sat_ff, res_status_ff};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      cmd_ff        <= cmd_in;
      layer_ff      <= layer_in;
      ladder_ff     <= ladder_in;
      wafer_ff      <= wafer_in;
      hybrid_ff     <= hybrid_in;
      degree_ff     <= degree_in;
      cidx_ff       <= cidx_in;
      coef_ff       <= coef_in;
      coord_ff      <= coord_in;
      entry_ff      <= entry_in;
      ok_ff         <= ok_in;
      cbase_ff      <= cbase_in;
      x_ff          <= x_in;
      t_ff          <= t_in;
      t1_ff         <= t1_in;
      t1_sat_ff     <= t1_sat_in;
      tc_ff         <= tc_in;
      tp_ff         <= tp_in;
      n_ff          <= n_in;
      d_ff          <= d_in;
      sum_ff        <= sum_in;
      sat_ff        <= sat_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      res_sat_ff    <= res_sat_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_user_ff;

   // The two multipliers are started together and must finish together.
   a_mul_lockstep : assert property (@(posedge clock) disable iff (reset)
      term_done == rec_done)
      else $error("term and recurrence multipliers out of step");

   // The term index never runs past the stored degree.
   a_term_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LSTART || state_ff == S_LWAIT) |-> (n_ff <= d_ff))
      else $error("term index beyond degree");

   // A saturation flag is only ever reported for an evaluated result.
   a_sat_eval : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_user_ff[2] |->
      (rsp_user_ff[1:0] == pscc_pkg::ST_EVALUATED))
      else $error("saturation flagged on a non-evaluated result");

   // Only evaluated results carry a nonzero value.
   a_zero_value : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && (rsp_user_ff[1:0] != pscc_pkg::ST_EVALUATED) |->
      (rsp_value_ff == '0))
      else $error("nonzero value on a write or error result");

   // No item is taken while the degree table is being cleared.
   a_clear_block : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_tready)
      else $error("item accepted during table clear");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Correction table testbench
// Drives write, evaluate and reserved-code items with random pacing and checks each result.
// ----------------------------------------------------------------------------
// A predictor in this file keeps its own copy of the degree and coefficient
// tables and computes the expected value, status and saturation flag of each
// accepted item. Results are compared in order with the oldest expectation.
// Evaluations that reach the coefficient table only touch entries whose
// coefficients up to the degree have been written since reset.
// ----------------------------------------------------------------------------
module tb;

   localparam int NLAY = 6, NLAD = 16, NWAF = 7, NHYB = 2, MAXD = 12;
   localparam int NENT = NLAY * NLAD * NWAF * NHYB;
   localparam longint TCLIP = 64'sd4294967295;

   // Packed from the top bit down, so layer lands in the lowest bits.
   typedef struct packed {
      logic [19:0] coord;
      logic [31:0] coef;
      logic [3:0]  cidx;
      logic [4:0]  degree;
      logic [1:0]  hybrid;
      logic [2:0]  wafer;
      logic [4:0]  ladder;
      logic [2:0]  layer;
   } cmd_item;

   typedef struct {
      logic [31:0]          value;
      pscc_pkg::status_type status;
      logic                 sat;
   } corr_result;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   // The predictor's own tables; written marks which coefficients are safe.
   logic signed [4:0]  deg_tab [NENT];
   logic signed [31:0] coef_tab[NENT][MAXD+1];
   bit                 written [NENT][MAXD+1];

   corr_result expected_q[$];
   int         errors = 0;
   int         burst_left = 0;
   bit         hold_valid = 0;

   per_sensor_chebyshev_correction_top dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   initial forever #5 clock = ~clock;

   // Run limit: clearing pass plus items at worst-case evaluate time and stalls.
   initial begin
      #50ms;
      $display("[per_sensor_chebyshev_correction_top] ERROR");
      $finish;
   end

   function automatic longint round_shift(longint v, int s);
      longint half;
      half = 64'sd1 <<< (s - 1);
      if (v < 0) return -((-v + half) >>> s);
      return (v + half) >>> s;
   endfunction

   function automatic longint clip_cheb(longint v, ref bit sat);
      if (v > TCLIP) begin sat = 1; return TCLIP; end
      if (v < -TCLIP) begin sat = 1; return -TCLIP; end
      return v;
   endfunction

   function automatic int entry_of(cmd_item it);
      return (((int'(it.layer) - 1) * NLAD + int'(it.ladder) - 1) * NWAF
              + int'(it.wafer) - 1) * NHYB + int'(it.hybrid) - 1;
   endfunction

   // Computes the answer to one item and updates the predictor tables.
   function automatic corr_result predict_correction(pscc_pkg::cmd_type cmd, cmd_item it);
      corr_result r;
      int e, d, n;
      longint a, x, t, tp, tc, tn, sum;
      bit sat;
      r.value = '0; r.status = pscc_pkg::ST_RANGE_ERR; r.sat = 0;
      if (cmd == pscc_pkg::CMD_RESERVED || it.layer < 1 || it.layer > NLAY
          || it.ladder < 1 || it.ladder > NLAD || it.wafer < 1 || it.wafer > NWAF
          || it.hybrid < 1 || it.hybrid > NHYB)
         return r;
      e = entry_of(it);
      case (cmd)
         pscc_pkg::CMD_WR_DEGREE: begin
            deg_tab[e] = it.degree;
            r.status = pscc_pkg::ST_WRITE_OK;
         end
         pscc_pkg::CMD_WR_COEF: begin
            if (it.cidx <= MAXD) begin
               coef_tab[e][it.cidx] = it.coef;
               written[e][it.cidx] = 1;
               r.status = pscc_pkg::ST_WRITE_OK;
            end
         end
         default: begin
            d = int'(deg_tab[e]);
            if (d < 0 || d > MAXD) begin
               r.status = pscc_pkg::ST_NO_CORR;
            end else begin
               sat = 0;
               a = longint'($signed(it.coord));
               if (a < 0) a = -a;
               x = (a + 1) / 3;
               t = 2 * x - 65536;
               tp = 64'sd1 <<< 30;
               tc = clip_cheb(t * 16384, sat);
               sum = round_shift(longint'(coef_tab[e][0]) * tp, 30);
               if (d >= 1) sum += round_shift(longint'(coef_tab[e][1]) * tc, 30);
               for (n = 2; n <= d; n++) begin
                  tn = clip_cheb(round_shift(t * tc, 15) - tp, sat);
                  sum += round_shift(longint'(coef_tab[e][n]) * tn, 30);
                  tp = tc;
                  tc = tn;
               end
               if (d < 1) sat = 0;
               if (sum > 64'sd2147483647) begin sum = 64'sd2147483647; sat = 1; end
               if (sum < -64'sd2147483648) begin sum = -64'sd2147483648; sat = 1; end
               r.value = sum[31:0];
               r.status = pscc_pkg::ST_EVALUATED;
               r.sat = sat;
            end
         end
      endcase
      return r;
   endfunction

   // Sends one item in bursts with random gaps; prediction happens at acceptance.
   task automatic send_item(pscc_pkg::cmd_type cmd, cmd_item it);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
         if (hold_valid && gap > 0) begin
            req_tvalid <= 0;
            hold_valid = 0;
         end
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_tvalid <= 1;
      hold_valid = 1;
      req_tuser <= cmd;
      req_tdata <= {6'd0, it};
      do @(posedge clock); while (!req_tready);
      expected_q.push_back(predict_correction(cmd, it));
      burst_left--;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      hold_valid = 0;
      burst_left = 0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // Receiver stall pattern: alternating stretches of ready, random and stalled.
   initial begin
      int mode;
      @(negedge reset);
      forever begin
         mode = $urandom_range(0, 2);
         repeat ($urandom_range(5, 60)) begin
            @(posedge clock);
            case (mode)
               0: rsp_tready <= 1;
               1: rsp_tready <= $urandom_range(0, 1);
               default: rsp_tready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // Result checker.
   always @(posedge clock) begin
      corr_result exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected result value=%h user=%b", rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            exp_r = expected_q.pop_front();
            if (rsp_tuser[1:0] !== exp_r.status) begin
               $error("status expected %0d actual %0d", exp_r.status, rsp_tuser[1:0]);
               errors++;
            end
            if (rsp_tdata !== exp_r.value) begin
               $error("value expected %h actual %h", exp_r.value, rsp_tdata);
               errors++;
            end
            if (rsp_tuser[2] !== exp_r.sat) begin
               $error("saturated expected %0d actual %0d", exp_r.sat, rsp_tuser[2]);
               errors++;
            end
         end
      end
   end

   function automatic cmd_item rand_addr();
      cmd_item it;
      it = '0;
      it.layer = 3'($urandom_range(1, NLAY));
      it.ladder = 5'($urandom_range(1, NLAD));
      it.wafer = 3'($urandom_range(1, NWAF));
      it.hybrid = 2'($urandom_range(1, NHYB));
      it.degree = 5'($urandom);
      it.cidx = 4'($urandom);
      it.coef = $urandom;
      it.coord = 20'($urandom);
      return it;
   endfunction

   // Coefficient values: mostly moderate, sometimes at the extremes.
   function automatic logic [31:0] rand_coef();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom;
         default: return 32'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
      endcase
   endfunction

   function automatic logic [19:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 20'h7ffff;
         1: return 20'h80000;
         2: return 20'($urandom);
         default: return 20'($signed($urandom_range(0, 2 * 196608)) - 196608);
      endcase
   endfunction

   // Loads a full entry: every coefficient, then the degree.
   task automatic load_entry(cmd_item base, int deg, bit extreme);
      cmd_item it;
      it = base;
      for (int k = 0; k <= MAXD; k++) begin
         it.cidx = 4'(k);
         it.coef = extreme ? ((k % 2) ? 32'h80000000 : 32'h7fffffff) : rand_coef();
         send_item(pscc_pkg::CMD_WR_COEF, it);
      end
      it.degree = 5'(deg);
      send_item(pscc_pkg::CMD_WR_DEGREE, it);
   endtask

   function automatic bit entry_ready(cmd_item it);
      int e;
      e = entry_of(it);
      for (int k = 0; k <= MAXD; k++)
         if (!written[e][k]) return 0;
      return 1;
   endfunction

   task automatic test_directed();
      cmd_item it, lo, hi;
      lo = rand_addr(); lo.layer = 3'd1; lo.ladder = 5'd1; lo.wafer = 3'd1;
      lo.hybrid = 2'd1;
      hi = rand_addr(); hi.layer = 3'(NLAY); hi.ladder = 5'(NLAD); hi.wafer = 3'(NWAF);
      hi.hybrid = 2'(NHYB);
      // Evaluating a fresh entry finds no correction.
      send_item(pscc_pkg::CMD_EVALUATE, lo);
      // Index errors on each field, a bad coefficient index and the reserved code.
      it = lo; it.layer = 3'd0; send_item(pscc_pkg::CMD_EVALUATE, it);
      it = lo; it.layer = 3'd7; send_item(pscc_pkg::CMD_WR_DEGREE, it);
      it = lo; it.ladder = 5'd0; send_item(pscc_pkg::CMD_WR_DEGREE, it);
      it = lo; it.ladder = 5'd31; send_item(pscc_pkg::CMD_EVALUATE, it);
      it = lo; it.wafer = 3'd0; send_item(pscc_pkg::CMD_WR_COEF, it);
      it = lo; it.hybrid = 2'd3; send_item(pscc_pkg::CMD_EVALUATE, it);
      it = lo; it.cidx = 4'd15; send_item(pscc_pkg::CMD_WR_COEF, it);
      send_item(pscc_pkg::CMD_RESERVED, lo);
      load_entry(lo, MAXD, 1);
      load_entry(hi, MAXD, 0);
      it = lo; it.coord = 20'h7ffff; send_item(pscc_pkg::CMD_EVALUATE, it);
      it = lo; it.coord = 20'h80000; send_item(pscc_pkg::CMD_EVALUATE, it);
      it = hi; it.coord = 20'h00000; send_item(pscc_pkg::CMD_EVALUATE, it);
      it = hi; it.coord = 20'd196608; send_item(pscc_pkg::CMD_EVALUATE, it);
      // Degrees zero, above the maximum and the last write winning.
      it = hi; it.degree = 5'd0; send_item(pscc_pkg::CMD_WR_DEGREE, it);
      it.coord = 20'h7ffff; send_item(pscc_pkg::CMD_EVALUATE, it);
      it = hi; it.degree = 5'sd15; send_item(pscc_pkg::CMD_WR_DEGREE, it);
      send_item(pscc_pkg::CMD_EVALUATE, it);
      it = hi; it.degree = 5'sd13; send_item(pscc_pkg::CMD_WR_DEGREE, it);
      it.degree = 5'd1; send_item(pscc_pkg::CMD_WR_DEGREE, it);
      send_item(pscc_pkg::CMD_EVALUATE, it);
      drain();
   endtask

   task automatic test_random(int count);
      cmd_item pool[$];
      cmd_item it;
      int sel;
      for (int k = 0; k < 6; k++) begin
         it = rand_addr();
         load_entry(it, $urandom_range(0, MAXD), 0);
         pool.push_back(it);
      end
      repeat (count) begin
         sel = $urandom_range(0, 99);
         it = pool[$urandom_range(0, pool.size() - 1)];
         if (sel < 55) begin
            it.coord = rand_coord();
            send_item(pscc_pkg::CMD_EVALUATE, it);
         end else if (sel < 70) begin
            it.cidx = 4'($urandom_range(0, MAXD));
            it.coef = rand_coef();
            send_item(pscc_pkg::CMD_WR_COEF, it);
         end else if (sel < 80) begin
            it.degree = ($urandom_range(0, 4) == 0) ? 5'($urandom) :
                        5'($urandom_range(0, 3));
            send_item(pscc_pkg::CMD_WR_DEGREE, it);
         end else if (sel < 85) begin
            it = rand_addr();
            load_entry(it, $urandom_range(0, MAXD), 0);
            pool.push_back(it);
         end else begin
            // Noise: raw fields, kept away from unwritten coefficients.
            it = cmd_item'(74'({$urandom, $urandom, $urandom}));
            sel = $urandom_range(0, 3);
            if (sel == pscc_pkg::CMD_EVALUATE && it.layer >= 1 && it.layer <= NLAY
                && it.ladder >= 1 && it.ladder <= NLAD && it.wafer >= 1
                && it.wafer <= NWAF && it.hybrid >= 1 && it.hybrid <= NHYB
                && !entry_ready(it))
               it.hybrid = 2'd0;
            send_item(pscc_pkg::cmd_type'(sel), it);
         end
      end
      drain();
   endtask

   initial begin
      for (int e = 0; e < NENT; e++) begin
         deg_tab[e] = -5'sd1;
         for (int k = 0; k <= MAXD; k++) begin
            coef_tab[e][k] = '0;
            written[e][k] = 0;
         end
      end
      repeat (2) @(posedge clock);
      reset <= 0;
      test_directed();
      test_random(880);
      if (errors == 0 && expected_q.size() == 0)
         $display("[per_sensor_chebyshev_correction_top] OK");
      else
         $display("[per_sensor_chebyshev_correction_top] ERROR");
      $finish;
   end
endmodule

// ===== sim.f =====
hdl/pscc_pkg.sv
hdl/pscc_ram.sv
hdl/pscc_mul.sv
hdl/per_sensor_chebyshev_correction_top.sv
dv/tb.sv
